FILE: rtl/core/tps_pkg.sv
// Shared types and constants of the text pretokenizer splitter.
// Holds the chunk kinds, the character codes and the result bundle format.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tps_pkg;

  // Chunk kinds; KindWs doubles as "no open chunk" in the open-chunk state
  typedef enum logic [2:0] {
    KindWs     = 3'd0,
    KindLetter = 3'd1,
    KindDigit  = 3'd2,
    KindOther  = 3'd3,
    KindContr  = 3'd4
  } kind_e;

  // Character codes
  localparam logic [7:0] ChApos  = 8'h27;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChS     = 8'h73;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChM     = 8'h6D;
  localparam logic [7:0] ChD     = 8'h64;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChV     = 8'h76;
  localparam logic [7:0] ChL     = 8'h6C;
  localparam logic [7:0] ChE     = 8'h65;

  // Most result words one text byte can cause
  localparam int unsigned MaxRes = 5;
  localparam int unsigned CntW   = $clog2(MaxRes + 1);
  localparam int unsigned IdxW   = $clog2(MaxRes);

  // Default depth of the bundle queue between front and back
  localparam int unsigned QDepth = 2;

  // One result word
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    kind_e      kind;
    logic       run_last;
  } res_t;

  // All result words caused by one text byte
  typedef struct packed {
    res_t [MaxRes-1:0] r;
    logic [CntW-1:0]   n;
  } bundle_t;

  // Read side of the bundle queue
  typedef struct packed {
    logic    valid;
    bundle_t data;
  } q_rd_t;

endpackage

`default_nettype wire

FILE: rtl/core/tps_front.sv
// Front end: classifies each text byte and builds its bundle of result words.
// Keeps the chunk, whitespace, lookahead and one-word delay state. Uses tps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tps_front import tps_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] text_byte_i,
  input  wire logic       end_of_text_i,
  input  wire logic       accept_i,
  output bundle_t         bundle_o,
  output logic            bundle_valid_o
);

  typedef struct packed {
    kind_e       chunk_class;
    logic [1:0]  space_run;
    logic [7:0]  held_space;
    logic [7:0]  la_byte;
    logic [1:0]  la_cnt;
    logic        prefix;
    logic [7:0]  d_byte;
    logic        d_valid;
    logic        d_first;
    kind_e       d_kind;
  } st_t;

  typedef struct packed {
    st_t     s;
    bundle_t b;
  } work_t;

  st_t state_q, state_d;
  work_t w;

  function automatic logic is_ws(logic [7:0] c);
    return c == ChSpace || c == ChLf || c == ChTab || c == ChCr || c == ChFf || c == ChVt;
  endfunction

  function automatic kind_e classify(logic [7:0] c);
    kind_e k;
    if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)) k = KindLetter;
    else if (c >= 8'h30 && c <= 8'h39) k = KindDigit;
    else k = KindOther;
    return k;
  endfunction

  // Append a result word; words past the bundle size are dropped
  function automatic work_t f_push(work_t wi, logic [7:0] c, logic first, logic last,
                                   kind_e kind);
    work_t o;
    o = wi;
    if (o.b.n < CntW'(MaxRes)) begin
      o.b.r[o.b.n[IdxW-1:0]] = '{data: c, first: first, last: last, kind: kind,
                                 run_last: 1'b0};
      o.b.n = o.b.n + 1'b1;
    end
    return o;
  endfunction

  // Send a byte through the one-word delay stage
  function automatic work_t f_emit(work_t wi, logic [7:0] c, logic first, kind_e kind);
    work_t o;
    o = wi;
    if (o.s.d_valid) o = f_push(o, o.s.d_byte, o.s.d_first, first, o.s.d_kind);
    o.s.d_byte  = c;
    o.s.d_first = first;
    o.s.d_kind  = kind;
    o.s.d_valid = 1'b1;
    return o;
  endfunction

  function automatic work_t f_start(work_t wi, logic [7:0] c, kind_e kind);
    work_t o;
    o = wi;
    if (o.s.prefix) begin
      o = f_emit(o, ChSpace, 1'b1, kind);
      o = f_emit(o, c, 1'b0, kind);
      o.s.prefix = 1'b0;
    end else begin
      o = f_emit(o, c, 1'b1, kind);
    end
    o.s.chunk_class = kind;
    return o;
  endfunction

  function automatic work_t f_regular(work_t wi, logic [7:0] c);
    work_t o;
    kind_e k;
    o = wi;
    k = classify(c);
    if (is_ws(c)) begin
      unique case (o.s.space_run)
        2'd0: begin
          o.s.chunk_class = KindWs;
          o.s.held_space  = c;
          o.s.space_run   = 2'd1;
        end
        2'd1: begin
          o = f_emit(o, o.s.held_space, 1'b1, KindWs);
          o = f_emit(o, c, 1'b0, KindWs);
          o.s.space_run = 2'd2;
        end
        default: o = f_emit(o, c, 1'b0, KindWs);
      endcase
    end else begin
      if (o.s.space_run == 2'd1) o.s.prefix = 1'b1;
      o.s.space_run = 2'd0;
      if (c == ChApos && o.s.chunk_class != KindOther) begin
        o.s.la_cnt = 2'd1;
      end else if (o.s.chunk_class == k) begin
        o = f_emit(o, c, 1'b0, k);
      end else begin
        o = f_start(o, c, k);
      end
    end
    return o;
  endfunction

  function automatic work_t f_contr_done(work_t wi);
    work_t o;
    o = wi;
    o.s.prefix      = 1'b0;
    o.s.chunk_class = KindContr;
    o.s.la_cnt      = 2'd0;
    return o;
  endfunction

  function automatic work_t f_take(work_t wi, logic [7:0] c);
    work_t o;
    logic [7:0] s;
    o = wi;
    s = o.s.la_byte;
    unique case (o.s.la_cnt)
      2'd0: o = f_regular(o, c);
      2'd1: begin
        if (c == ChS || c == ChT || c == ChM || c == ChD) begin
          o = f_emit(o, ChApos, 1'b1, KindContr);
          o = f_emit(o, c, 1'b0, KindContr);
          o = f_contr_done(o);
        end else if (c == ChR || c == ChV || c == ChL) begin
          o.s.la_byte = c;
          o.s.la_cnt  = 2'd2;
        end else begin
          o.s.la_cnt = 2'd0;
          o = f_start(o, ChApos, KindOther);
          o = f_regular(o, c);
        end
      end
      default: begin
        if (((s == ChR || s == ChV) && c == ChE) || (s == ChL && c == ChL)) begin
          o = f_emit(o, ChApos, 1'b1, KindContr);
          o = f_emit(o, s, 1'b0, KindContr);
          o = f_emit(o, c, 1'b0, KindContr);
          o = f_contr_done(o);
        end else begin
          o.s.la_cnt = 2'd0;
          o = f_start(o, ChApos, KindOther);
          o = f_regular(o, s);
          o = f_regular(o, c);
        end
      end
    endcase
    return o;
  endfunction

  // Drain held bytes at the end of the text
  function automatic work_t f_flush(work_t wi);
    work_t o;
    logic [1:0] n;
    o = wi;
    n = o.s.la_cnt;
    if (n != 2'd0) begin
      o.s.la_cnt = 2'd0;
      o = f_start(o, ChApos, KindOther);
      if (n >= 2'd2) o = f_regular(o, o.s.la_byte);
    end
    if (o.s.space_run == 2'd1) o = f_emit(o, o.s.held_space, 1'b1, KindWs);
    o.s.space_run = 2'd0;
    if (o.s.d_valid) o = f_push(o, o.s.d_byte, o.s.d_first, 1'b1, o.s.d_kind);
    o.s = '0;
    return o;
  endfunction

  // Work out the bundle and the next state for the byte at the port
  always_comb begin
    w.s = state_q;
    w.b = '0;
    w = f_take(w, text_byte_i);
    if (end_of_text_i) w = f_flush(w);
    if (w.b.n != '0) w.b.r[IdxW'(w.b.n - 1'b1)].run_last = 1'b1;
    state_d        = accept_i ? w.s : state_q;
    bundle_o       = w.b;
    bundle_valid_o = accept_i && (w.b.n != '0);
  end

  // Advance the state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tps_queue.sv
// Bundle queue between the front end and the back end.
// A small register ring with a count; uses tps_pkg for the bundle type.
`timescale 1ns / 1ps
`default_nettype none

module tps_queue import tps_pkg::*; #(
  parameter int unsigned Depth = QDepth
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    wr_valid_i,
  input  bundle_t      wr_data_i,
  output logic         full_o,
  output q_rd_t        rd_o,
  input  wire logic    rd_pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntQW = $clog2(Depth + 1);

  bundle_t [Depth-1:0] mem_q;
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntQW-1:0] cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o   = (cnt_q == CntQW'(Depth));
  assign rd_o     = '{valid: (cnt_q != '0), data: mem_q[rd_ptr_q]};
  assign do_wr    = wr_valid_i && !full_o;
  assign do_rd    = rd_pop_i && (cnt_q != '0);

  // Advance pointers with wrap and track the fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    if (do_rd) rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    if (do_wr && !do_rd) cnt_d = cnt_q + 1'b1;
    else if (!do_wr && do_rd) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming bundle
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

`default_nettype wire

FILE: rtl/core/tps_back.sv
// Back end: hands out the words of the head bundle one per cycle while pop is held.
// Pops the bundle after its last word. Uses tps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tps_back import tps_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  q_rd_t           head_i,
  output logic            head_pop_o,
  input  wire logic       pop,
  output logic            empty,
  output logic [7:0]      out_byte_o,
  output logic            chunk_first_o,
  output logic            chunk_last_o,
  output logic [2:0]      chunk_kind_o,
  output logic            run_last_o
);

  logic [IdxW-1:0] idx_q, idx_d;
  res_t            cur;
  logic            take;
  logic            at_end;

  assign cur           = head_i.data.r[idx_q];
  assign empty         = !head_i.valid;
  assign take          = pop && head_i.valid;
  assign at_end        = (CntW'(idx_q) == head_i.data.n - 1'b1);
  assign head_pop_o    = take && at_end;
  assign out_byte_o    = cur.data;
  assign chunk_first_o = cur.first;
  assign chunk_last_o  = cur.last;
  assign chunk_kind_o  = 3'(cur.kind);
  assign run_last_o    = cur.run_last;

  // Step to the next word, wrap to zero on the bundle's last word
  always_comb begin
    idx_d = idx_q;
    if (take) idx_d = at_end ? '0 : idx_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/text_pretokenizer_splitter_unit.sv
// Top level of the text pretokenizer splitter: front end, bundle queue, back end.
// Depends on tps_pkg, tps_front, tps_queue and tps_back.
//
//   channel   direction  handshake          payload
//   text in   in         push / full        text_byte_i, end_of_text_i
//   result    out        pop / empty        out_byte_o, chunk_first_o, chunk_last_o,
//                                           chunk_kind_o, run_last_o
//
// A text byte is classified in the cycle it is accepted; its result words (0 to 5)
// enter the queue, when there are any, as one registered bundle behind those held.
// The back end hands out one word per cycle while pop is held, so the sustained
// rate is one byte per cycle while bytes average one word each; the word count per
// byte sets the figure. full rises only when the queue holds QueueDepth bundles.
// Reset empties the queue and returns the splitter to the start of a new text.
`timescale 1ns / 1ps
`default_nettype none

module text_pretokenizer_splitter_unit import tps_pkg::*; #(
  parameter int unsigned QueueDepth = QDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] text_byte_i,
  input  wire logic       end_of_text_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte_o,
  output logic            chunk_first_o,
  output logic            chunk_last_o,
  output logic [2:0]      chunk_kind_o,
  output logic            run_last_o
);

  bundle_t bundle;
  logic    bundle_valid;
  q_rd_t   head;
  logic    head_pop;
  logic    accept;

  assign accept = push && !full;

  tps_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .text_byte_i    (text_byte_i),
    .end_of_text_i  (end_of_text_i),
    .accept_i       (accept),
    .bundle_o       (bundle),
    .bundle_valid_o (bundle_valid)
  );

  tps_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (bundle_valid),
    .wr_data_i  (bundle),
    .full_o     (full),
    .rd_o       (head),
    .rd_pop_i   (head_pop)
  );

  tps_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .head_pop_o    (head_pop),
    .pop           (pop),
    .empty         (empty),
    .out_byte_o    (out_byte_o),
    .chunk_first_o (chunk_first_o),
    .chunk_last_o  (chunk_last_o),
    .chunk_kind_o  (chunk_kind_o),
    .run_last_o    (run_last_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/tps_checker.sv
// Port-level checks of the text pretokenizer splitter, bound to the top level.
// Depends on tps_pkg and text_pretokenizer_splitter_unit.
`timescale 1ns / 1ps
`default_nettype none

module tps_checker import tps_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       push,
  input wire logic       full,
  input wire logic [7:0] text_byte_i,
  input wire logic       end_of_text_i,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_byte_o,
  input wire logic       chunk_first_o,
  input wire logic       chunk_last_o,
  input wire logic [2:0] chunk_kind_o,
  input wire logic       run_last_o
);

  // Show no word straight after reset is seen
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result shown after reset");

  // Open every contraction with the apostrophe
  a_contr_apos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && chunk_first_o && chunk_kind_o == 3'(KindContr)) |-> out_byte_o == ChApos)
    else $error("contraction does not start with an apostrophe");

  // Start a chunk right after a chunk end, and only then
  a_last_then_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop) |=> (empty || (chunk_first_o == $past(chunk_last_o))))
    else $error("chunk boundary marks out of step");

  // Hold a stalled result: its byte and run_last flag stay put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(run_last_o)))
    else $error("stalled result changed");

endmodule

bind text_pretokenizer_splitter_unit tps_checker u_tps_checker (.*);

`default_nettype wire

FILE: dv/tb.sv
// Testbench for text_pretokenizer_splitter_unit: directed texts, then random texts.
// Predicts chunk words in-line and checks every popped word field by field.
// Depends on tps_pkg and the splitter RTL.
`timescale 1ns / 1ps

module tb;
  import tps_pkg::*;

  localparam int unsigned TextBytes = 330;
  localparam int unsigned TailBytes = 40;
  localparam int unsigned HoldCycles = 150;

  typedef struct packed {
    logic [7:0] text;
    logic       eot;
  } text_item_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] text_byte_i = 8'h00;
  logic       end_of_text_i = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte_o;
  logic       chunk_first_o;
  logic       chunk_last_o;
  logic [2:0] chunk_kind_o;
  logic       run_last_o;

  text_item_t text_q[$];
  res_t       chunk_words_q[$];
  res_t       step_words_q[$];
  res_t       got_word;

  int         errors = 0;
  int         bytes_taken = 0;
  int         send_gap = 0;
  int         take_gap = 0;
  logic       hold_off = 1'b0;

  // Splitter state as the predictor tracks it
  kind_e      open_kind;
  int         ws_run;
  logic [7:0] ws_held;
  logic [7:0] apos_next;
  int         apos_cnt;
  logic       prefix_due;
  logic [7:0] stage_byte;
  logic       stage_live;
  logic       stage_first;
  kind_e      stage_kind;

  text_pretokenizer_splitter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte_o),
    .chunk_first_o (chunk_first_o),
    .chunk_last_o  (chunk_last_o),
    .chunk_kind_o  (chunk_kind_o),
    .run_last_o    (run_last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic is_blank(input logic [7:0] b);
    return b == ChSpace || b == ChLf || b == ChTab || b == ChCr || b == ChFf || b == ChVt;
  endfunction

  function automatic kind_e byte_kind(input logic [7:0] b);
    if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) return KindLetter;
    if (b >= "0" && b <= "9") return KindDigit;
    return KindOther;
  endfunction

  task automatic clear_split_state();
    open_kind   = KindWs;
    ws_run      = 0;
    ws_held     = 8'h00;
    apos_next   = 8'h00;
    apos_cnt    = 0;
    prefix_due  = 1'b0;
    stage_byte  = 8'h00;
    stage_live  = 1'b0;
    stage_first = 1'b0;
    stage_kind  = KindWs;
  endtask

  // Release the staged byte (its last flag is the new byte's first flag), stage the new one
  task automatic stage_word(input logic [7:0] b, input logic first, input kind_e k);
    res_t w;
    if (stage_live && step_words_q.size() < MaxRes) begin
      w.data     = stage_byte;
      w.first    = stage_first;
      w.last     = first;
      w.kind     = stage_kind;
      w.run_last = 1'b0;
      step_words_q.push_back(w);
    end
    stage_byte  = b;
    stage_first = first;
    stage_kind  = k;
    stage_live  = 1'b1;
  endtask

  task automatic open_chunk(input logic [7:0] b, input kind_e k);
    if (prefix_due) begin
      stage_word(ChSpace, 1'b1, k);
      stage_word(b, 1'b0, k);
      prefix_due = 1'b0;
    end else begin
      stage_word(b, 1'b1, k);
    end
    open_kind = k;
  endtask

  task automatic split_plain(input logic [7:0] b);
    kind_e k;
    if (is_blank(b)) begin
      if (ws_run == 0) begin
        open_kind = KindWs;
        ws_held   = b;
        ws_run    = 1;
      end else if (ws_run == 1) begin
        stage_word(ws_held, 1'b1, KindWs);
        stage_word(b, 1'b0, KindWs);
        ws_run = 2;
      end else begin
        stage_word(b, 1'b0, KindWs);
      end
    end else begin
      if (ws_run == 1) prefix_due = 1'b1;
      ws_run = 0;
      if (b == ChApos && open_kind != KindOther) begin
        apos_cnt = 1;
      end else begin
        k = byte_kind(b);
        if (open_kind == k) stage_word(b, 1'b0, k);
        else open_chunk(b, k);
      end
    end
  endtask

  task automatic close_contraction();
    prefix_due = 1'b0;
    open_kind  = KindContr;
    apos_cnt   = 0;
  endtask

  task automatic split_take(input logic [7:0] b);
    if (apos_cnt == 0) begin
      split_plain(b);
    end else if (apos_cnt == 1) begin
      if (b == ChS || b == ChT || b == ChM || b == ChD) begin
        stage_word(ChApos, 1'b1, KindContr);
        stage_word(b, 1'b0, KindContr);
        close_contraction();
      end else if (b == ChR || b == ChV || b == ChL) begin
        apos_next = b;
        apos_cnt  = 2;
      end else begin
        apos_cnt = 0;
        open_chunk(ChApos, KindOther);
        split_plain(b);
      end
    end else begin
      if (((apos_next == ChR || apos_next == ChV) && b == ChE) ||
          (apos_next == ChL && b == ChL)) begin
        stage_word(ChApos, 1'b1, KindContr);
        stage_word(apos_next, 1'b0, KindContr);
        stage_word(b, 1'b0, KindContr);
        close_contraction();
      end else begin
        apos_cnt = 0;
        open_chunk(ChApos, KindOther);
        split_plain(apos_next);
        split_plain(b);
      end
    end
  endtask

  // Flush held bytes at the end of a text
  task automatic split_flush();
    res_t w;
    int   n;
    if (apos_cnt != 0) begin
      n = apos_cnt;
      apos_cnt = 0;
      open_chunk(ChApos, KindOther);
      if (n >= 2) split_plain(apos_next);
    end
    if (ws_run == 1) stage_word(ws_held, 1'b1, KindWs);
    ws_run = 0;
    if (stage_live && step_words_q.size() < MaxRes) begin
      w.data     = stage_byte;
      w.first    = stage_first;
      w.last     = 1'b1;
      w.kind     = stage_kind;
      w.run_last = 1'b0;
      step_words_q.push_back(w);
    end
  endtask

  // Work out the chunk words one accepted text byte causes and queue them
  task automatic split_text_byte(input logic [7:0] b, input logic eot);
    step_words_q.delete();
    split_take(b);
    if (eot) begin
      split_flush();
      clear_split_state();
    end
    if (step_words_q.size() > 0) step_words_q[$].run_last = 1'b1;
    foreach (step_words_q[i]) chunk_words_q.push_back(step_words_q[i]);
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic add_byte(input logic [7:0] b, input logic eot);
    text_item_t it;
    it.text = b;
    it.eot  = eot;
    text_q.push_back(it);
  endtask

  task automatic add_str(input string s, input logic close);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], close && i == s.len() - 1);
  endtask

  // Build one random text, mostly well-formed words, numbers, spaces and contractions
  task automatic add_random_text();
    logic [7:0] txt[$];
    int         len;
    int         r;
    len = $urandom_range(1, 24);
    while (txt.size() < len) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        txt.push_back(8'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 25)));
      end else if (r < 47) begin
        txt.push_back(8'("0" + $urandom_range(0, 9)));
      end else if (r < 62) begin
        txt.push_back(ChSpace);
      end else if (r < 68) begin
        txt.push_back(8'(ChTab + $urandom_range(0, 4)));
      end else if (r < 80) begin
        txt.push_back(ChApos);
        case ($urandom_range(0, 9))
          0: txt.push_back(ChS);
          1: txt.push_back(ChT);
          2: txt.push_back(ChM);
          3: txt.push_back(ChD);
          4: begin txt.push_back(ChR); txt.push_back(ChE); end
          5: begin txt.push_back(ChV); txt.push_back(ChE); end
          6: begin txt.push_back(ChL); txt.push_back(ChL); end
          7: ;
          8: begin txt.push_back(ChR); txt.push_back(8'("a" + $urandom_range(0, 25))); end
          default: begin txt.push_back(ChL); txt.push_back(8'($urandom_range(0, 255))); end
        endcase
      end else if (r < 92) begin
        txt.push_back(8'($urandom_range(8'h21, 8'h2F)));
      end else begin
        txt.push_back(8'($urandom_range(0, 255)));
      end
    end
    foreach (txt[i]) add_byte(txt[i], i == txt.size() - 1);
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push          <= 1'b0;
      text_byte_i   <= 8'h00;
      end_of_text_i <= 1'b0;
      send_gap      <= 0;
    end else begin
      if (push && !full) begin
        split_text_byte(text_byte_i, end_of_text_i);
        void'(text_q.pop_front());
        bytes_taken++;
      end
      // Hold an offered byte until the splitter takes it
      if (push && full) begin
      end else if (send_gap > 0 && !hold_off) begin
        push     <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (text_q.size() > 0 &&
                   (hold_off || text_q.size() < TailBytes || $urandom_range(0, 7) != 0)) begin
        push          <= 1'b1;
        text_byte_i   <= text_q[0].text;
        end_of_text_i <= text_q[0].eot;
      end else begin
        push <= 1'b0;
        if (text_q.size() > 0) send_gap <= $urandom_range(0, 11);
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop      <= 1'b0;
      take_gap <= 0;
    end else begin
      if (pop && !empty) begin
        if (chunk_words_q.size() == 0) begin
          $error("unexpected word: out_byte %02h", out_byte_o);
          errors++;
        end else begin
          got_word = chunk_words_q.pop_front();
          if (out_byte_o !== got_word.data) begin
            $error("out_byte: expected %02h, actual %02h", got_word.data, out_byte_o);
            errors++;
          end
          if (chunk_first_o !== got_word.first) begin
            $error("chunk_first: expected %0d, actual %0d", got_word.first, chunk_first_o);
            errors++;
          end
          if (chunk_last_o !== got_word.last) begin
            $error("chunk_last: expected %0d, actual %0d", got_word.last, chunk_last_o);
            errors++;
          end
          if (chunk_kind_o !== got_word.kind) begin
            $error("chunk_kind: expected %0d, actual %0d", got_word.kind, chunk_kind_o);
            errors++;
          end
          if (run_last_o !== got_word.run_last) begin
            $error("run_last: expected %0d, actual %0d", got_word.run_last, run_last_o);
            errors++;
          end
        end
      end
      // Stall the result side in random bursts that start only before the tail, and during hold_off
      if (hold_off) begin
        pop <= 1'b0;
      end else if (take_gap > 0) begin
        pop      <= 1'b0;
        take_gap <= take_gap - 1;
      end else if (text_q.size() < TailBytes || $urandom_range(0, 7) != 0) begin
        pop <= 1'b1;
      end else begin
        pop      <= 1'b0;
        take_gap <= $urandom_range(0, 11);
      end
    end
  end

  // Block the result side for a long stretch so the input backs up
  initial begin
    wait (bytes_taken >= 60);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    clear_split_state();
    // Letters, space dropped before 'll, then 'r cut by the end
    add_str("a 'll'r", 1'b1);
    // Digits, whitespace run, broken 'r, lone apostrophe cut by the end
    add_str("9  'rx'", 1'b1);
    // Top byte, apostrophe inside an other run, trailing single tab
    add_byte(8'hFF, 1'b0);
    add_str("!'s\t", 1'b1);
    // Back-to-back contractions
    add_str("'t'd're've", 1'b0);
    // Zero byte closes the text
    add_byte(8'h00, 1'b1);
    while (text_q.size() < TextBytes) add_random_text();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all bytes taken, all words seen, then a short settle
    while (text_q.size() != 0 || push || chunk_words_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (chunk_words_q.size() != 0) begin
      $error("%0d expected words never arrived", chunk_words_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
